>>> hdl/gbn_pkg.sv
// gbn_pkg: shared constants, codes, types and helpers for the go-back-n sender
// used by gbn_ctrl, gbn_dp, gbn_chk and go_back_n_sender; no dependencies
`default_nettype none

package gbn_pkg;

    // sizing of the sender
    localparam int WINDOW_MAX   = 8;
    localparam int BUF_DEPTH    = 16;
    localparam int SEQ_W        = 16;
    localparam int PAY_W        = 64;

    // config register widths
    localparam int WINREG_W     = 4;
    localparam int TMO_W        = 16;
    localparam int CFG_W        = 16;
    localparam int CFG_ADDR_W   = 1;

    // derived widths
    localparam int SEQ_MAX      = (1 << SEQ_W) - 1;
    localparam int CAPACITY     = (BUF_DEPTH < SEQ_MAX) ? BUF_DEPTH : SEQ_MAX;
    localparam int SLOT_W       = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
    localparam int CNT_W        = $clog2(CAPACITY + 1);
    localparam int WIN_W        = $clog2(WINDOW_MAX + 1);
    localparam int IDX_W        = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

    // stream widths
    localparam int S_FIELDS_W   = PAY_W + SEQ_W + 2;
    localparam int S_TDATA_W    = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int S_TUSER_W    = 2;
    localparam int M_FIELDS_W   = SEQ_W + PAY_W + 2;
    localparam int M_TDATA_W    = ((M_FIELDS_W + 7) / 8) * 8;

    // reset values
    localparam logic [WINREG_W-1:0] WIN_RST = WINREG_W'(4);
    localparam logic [TMO_W-1:0]    TMO_RST = TMO_W'(1000);
    localparam logic [SEQ_W-1:0]    SEQ_RST = SEQ_W'(1);

    // operation codes
    localparam logic [1:0] OP_NEW  = 2'd0;
    localparam logic [1:0] OP_ACK  = 2'd1;
    localparam logic [1:0] OP_TICK = 2'd2;

    // config register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_WINDOW  = CFG_ADDR_W'(0);
    localparam logic [CFG_ADDR_W-1:0] REG_TIMEOUT = CFG_ADDR_W'(1);

    // controller to datapath
    typedef struct packed {
        logic load_in;
        logic exec;
        logic send;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic out_free;
        logic resend;
        logic last_pkt;
    } t_sts;

    // slot sum below twice the depth folded back into the buffer
    function automatic logic [SLOT_W-1:0] wrap_slot(input logic [SLOT_W:0] sum);
        logic [SLOT_W:0] t;
        t = sum;
        if (sum >= (SLOT_W+1)'(BUF_DEPTH)) begin
            t = sum - (SLOT_W+1)'(BUF_DEPTH);
        end
        return t[SLOT_W-1:0];
    endfunction

endpackage

`default_nettype wire

>>> hdl/gbn_ctrl.sv
// gbn_ctrl: sequencing state machine of the go-back-n sender
// depends on gbn_pkg for the command and status types
`default_nettype none

module gbn_ctrl (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_s_tvalid,
    output logic           o_s_tready,
    input  gbn_pkg::t_sts  i_sts,
    output gbn_pkg::t_cmd  o_cmd
);
    import gbn_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_READ = 2'd2;
    localparam logic [1:0] S_SEND = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    // next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_s_tready = (r_state == S_IDLE);
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_sts.out_free) begin
                    o_cmd.exec = 1'b1;
                    n_state    = i_sts.resend ? S_READ : S_IDLE;
                end
            end
            S_READ: begin
                n_state = S_SEND;
            end
            S_SEND: begin
                if (i_sts.out_free) begin
                    o_cmd.send = 1'b1;
                    n_state    = i_sts.last_pkt ? S_IDLE : S_READ;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

>>> hdl/gbn_dp.sv
// gbn_dp: window state, timer, packet buffer and output word register
// depends on gbn_pkg for widths, codes, types and wrap_slot
`default_nettype none

module gbn_dp (
    input  wire                                i_clk,
    input  wire                                i_rst_n,
    input  gbn_pkg::t_cmd                      i_cmd,
    output gbn_pkg::t_sts                      o_sts,
    input  wire [gbn_pkg::S_TDATA_W-1:0]       i_s_tdata,
    input  wire [gbn_pkg::S_TUSER_W-1:0]       i_s_tuser,
    input  wire                                i_cfg_we,
    input  wire [gbn_pkg::CFG_ADDR_W-1:0]      i_cfg_addr,
    input  wire [gbn_pkg::CFG_W-1:0]           i_cfg_data,
    output logic                               o_m_tvalid,
    input  wire                                i_m_tready,
    output logic [gbn_pkg::M_TDATA_W-1:0]      o_m_tdata,
    output logic                               o_m_tuser,
    output logic                               o_m_tlast
);
    import gbn_pkg::*;

    // config registers
    logic [WINREG_W-1:0] r_win;
    logic [TMO_W-1:0]    r_tmo;

    // sender state
    logic [SEQ_W-1:0]  r_base,      n_base;
    logic [SEQ_W-1:0]  r_next,      n_next;
    logic [SLOT_W-1:0] r_base_slot, n_base_slot;
    logic [CNT_W-1:0]  r_sent,      n_sent;
    logic [TMO_W-1:0]  r_tcount,    n_tcount;
    logic              r_timer_on,  n_timer_on;
    logic [WIN_W-1:0]  r_m,         n_m;
    logic [IDX_W-1:0]  r_idx,       n_idx;

    // captured input word
    logic [1:0]        r_op;
    logic [PAY_W-1:0]  r_pay;
    logic [SEQ_W-1:0]  r_ack;
    logic              r_ack_corrupt;
    logic              r_ack_positive;

    // packet buffer
    logic [PAY_W-1:0]  r_mem [BUF_DEPTH];
    logic [PAY_W-1:0]  r_rd_data;
    logic [SLOT_W-1:0] rd_slot;
    logic [SLOT_W-1:0] wr_slot;
    logic              wr_en;

    // output word register
    logic              r_out_valid, n_out_valid;
    logic              r_out_sv,    n_out_sv;
    logic [SEQ_W-1:0]  r_out_seq,   n_out_seq;
    logic [PAY_W-1:0]  r_out_pay,   n_out_pay;
    logic              r_out_acc,   n_out_acc;
    logic              r_out_ta,    n_out_ta;
    logic              r_out_last,  n_out_last;

    // decode helpers
    logic [SEQ_W-1:0]  n_out;
    logic [WIN_W-1:0]  win_eff;
    logic              n_lt_cap;
    logic              n_lt_w;
    logic [SEQ_W-1:0]  n_plus1;
    logic [SEQ_W-1:0]  ack_d;
    logic              ack_ok;
    logic              d_le_sent;
    logic [TMO_W-1:0]  tcount_inc;
    logic [TMO_W-1:0]  limit;
    logic              expire;
    logic [WIN_W-1:0]  m_now;
    logic              out_free;

    // outstanding count, effective window and compares
    always_comb begin
        n_out     = r_next - r_base;
        win_eff   = WIN_W'(r_win);
        if (r_win == '0) begin
            win_eff = WIN_W'(1);
        end else if (32'(r_win) > WINDOW_MAX) begin
            win_eff = WIN_W'(WINDOW_MAX);
        end
        n_lt_cap  = (32'(n_out) < CAPACITY);
        n_lt_w    = (n_out < SEQ_W'(win_eff));
        n_plus1   = n_out + SEQ_W'(1);
        ack_ok    = !r_ack_corrupt && r_ack_positive;
        ack_d     = r_ack + SEQ_W'(1) - r_base;
        d_le_sent = (ack_d <= SEQ_W'(r_sent));
        tcount_inc = (r_tcount != '1) ? r_tcount + TMO_W'(1) : r_tcount;
        limit     = (r_tmo == '0) ? TMO_W'(1) : r_tmo;
        expire    = r_timer_on && (tcount_inc >= limit);
        m_now     = n_lt_w ? n_out[WIN_W-1:0] : win_eff;
        wr_slot   = wrap_slot({1'b0, r_base_slot} + n_out[SLOT_W:0]);
        rd_slot   = wrap_slot({1'b0, r_base_slot} + (SLOT_W+1)'(r_idx));
        out_free  = !r_out_valid || i_m_tready;
    end

    // status to the controller
    always_comb begin
        o_sts.out_free = out_free;
        o_sts.resend   = (r_op == OP_TICK) && expire && (m_now != '0);
        o_sts.last_pkt = (WIN_W'(r_idx) == r_m - WIN_W'(1));
    end

    // step execution and packet replay
    always_comb begin
        n_base      = r_base;
        n_next      = r_next;
        n_base_slot = r_base_slot;
        n_sent      = r_sent;
        n_tcount    = r_tcount;
        n_timer_on  = r_timer_on;
        n_m         = r_m;
        n_idx       = r_idx;
        wr_en       = 1'b0;
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_sv    = r_out_sv;
        n_out_seq   = r_out_seq;
        n_out_pay   = r_out_pay;
        n_out_acc   = r_out_acc;
        n_out_ta    = r_out_ta;
        n_out_last  = r_out_last;

        if (i_cmd.exec) begin
            // single result unless replaced below by a replay
            n_out_sv   = 1'b0;
            n_out_seq  = '0;
            n_out_pay  = '0;
            n_out_acc  = 1'b0;
            n_out_last = 1'b1;
            case (r_op)
                OP_NEW: begin
                    if (n_lt_cap) begin
                        wr_en     = 1'b1;
                        n_out_acc = 1'b1;
                        n_next    = r_next + SEQ_W'(1);
                        if (n_lt_w) begin
                            n_out_sv  = 1'b1;
                            n_out_seq = r_next;
                            n_out_pay = r_pay;
                            if (SEQ_W'(r_sent) < n_plus1) begin
                                n_sent = CNT_W'(n_plus1);
                            end
                            if (n_out == '0) begin
                                n_timer_on = 1'b1;
                                n_tcount   = '0;
                            end
                        end
                    end
                end
                OP_ACK: begin
                    if (ack_ok) begin
                        if (ack_d == '0) begin
                            if (n_out == '0) begin
                                n_timer_on = 1'b0;
                            end
                        end else if (d_le_sent) begin
                            n_base      = r_base + ack_d;
                            n_base_slot = wrap_slot({1'b0, r_base_slot} + ack_d[SLOT_W:0]);
                            n_sent      = r_sent - ack_d[CNT_W-1:0];
                            if (n_out == ack_d) begin
                                n_timer_on = 1'b0;
                            end else begin
                                n_timer_on = 1'b1;
                                n_tcount   = '0;
                            end
                        end
                    end
                end
                OP_TICK: begin
                    if (r_timer_on) begin
                        n_tcount = tcount_inc;
                        if (expire) begin
                            n_m   = m_now;
                            n_idx = '0;
                            if (r_sent < CNT_W'(m_now)) begin
                                n_sent = CNT_W'(m_now);
                            end
                            if (m_now == '0) begin
                                n_timer_on = 1'b0;
                            end else begin
                                n_timer_on = 1'b1;
                                n_tcount   = '0;
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
            n_out_ta    = n_timer_on;
            n_out_valid = !o_sts.resend;
        end

        // one buffered packet per replay word
        if (i_cmd.send) begin
            n_out_valid = 1'b1;
            n_out_sv    = 1'b1;
            n_out_seq   = r_base + SEQ_W'(r_idx);
            n_out_pay   = r_rd_data;
            n_out_acc   = 1'b0;
            n_out_ta    = r_timer_on;
            n_out_last  = o_sts.last_pkt;
            n_idx       = r_idx + IDX_W'(1);
        end
    end

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= WIN_RST;
            r_tmo <= TMO_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_WINDOW:  r_win <= i_cfg_data[WINREG_W-1:0];
                REG_TIMEOUT: r_tmo <= i_cfg_data[TMO_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base      <= SEQ_RST;
            r_next      <= SEQ_RST;
            r_base_slot <= '0;
            r_sent      <= '0;
            r_tcount    <= '0;
            r_timer_on  <= 1'b0;
            r_m         <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_base      <= n_base;
            r_next      <= n_next;
            r_base_slot <= n_base_slot;
            r_sent      <= n_sent;
            r_tcount    <= n_tcount;
            r_timer_on  <= n_timer_on;
            r_m         <= n_m;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    // input capture and output payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_op           <= i_s_tuser;
            r_pay          <= i_s_tdata[PAY_W-1:0];
            r_ack          <= i_s_tdata[PAY_W +: SEQ_W];
            r_ack_corrupt  <= i_s_tdata[PAY_W + SEQ_W];
            r_ack_positive <= i_s_tdata[PAY_W + SEQ_W + 1];
        end
        r_out_sv   <= n_out_sv;
        r_out_seq  <= n_out_seq;
        r_out_pay  <= n_out_pay;
        r_out_acc  <= n_out_acc;
        r_out_ta   <= n_out_ta;
        r_out_last <= n_out_last;
    end

    // packet buffer, one write and one registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && wr_en) begin
            r_mem[wr_slot] <= r_pay;
        end
        r_rd_data <= r_mem[rd_slot];
    end

    // master side
    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_sv;
    assign o_m_tlast  = r_out_last;
    assign o_m_tdata  = {{(M_TDATA_W - M_FIELDS_W){1'b0}},
                         r_out_ta, r_out_acc, r_out_pay, r_out_seq};

endmodule

`default_nettype wire

>>> hdl/go_back_n_sender.sv
// go_back_n_sender: top level of the go-back-n retransmitting sender
// depends on gbn_pkg, gbn_ctrl and gbn_dp
//
// Takes one word per step: a new message, an ack, or one tick of the internal
// retransmission timer, and answers with one or more output words, the final
// one marked by tlast. A new message, an ack, a plain tick or a tick whose
// expiry finds nothing outstanding is captured, then executed into the output
// register. An expiry that replays m packets (m up to the window) is captured
// and executed, then for each packet a registered read of the packet buffer is
// followed by an output load. The slave side is ready again once the last word
// of a step sits in the output register, so a new word may be taken while that
// one still waits downstream. Back-pressure on the master side stalls the
// execute and send steps. Configuration writes belong to idle periods only.
`default_nettype none

module go_back_n_sender (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    // slave side
    input  wire                            i_s_tvalid,
    output logic                           o_s_tready,
    // payload[63:0], ack_seq[79:64], ack_corrupt[80], ack_positive[81], zero pad
    input  wire [gbn_pkg::S_TDATA_W-1:0]   i_s_tdata,
    // operation[1:0]
    input  wire [gbn_pkg::S_TUSER_W-1:0]   i_s_tuser,
    // config port
    input  wire                            i_cfg_we,
    input  wire [gbn_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  wire [gbn_pkg::CFG_W-1:0]       i_cfg_data,
    // master side
    output logic                           o_m_tvalid,
    input  wire                            i_m_tready,
    // send_seq[15:0], send_payload[79:16], accepted[80], timer_active[81], zero pad
    output logic [gbn_pkg::M_TDATA_W-1:0]  o_m_tdata,
    // send_valid[0]
    output logic                           o_m_tuser,
    output logic                           o_m_tlast
);
    import gbn_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // sequencing
    gbn_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // state, buffer and output register
    gbn_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

endmodule

`default_nettype wire

>>> hdl/gbn_chk.sv
// gbn_chk: port-level checks on the go-back-n sender, bound to the top level
// depends on gbn_pkg for port widths
`default_nettype none

module gbn_chk (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_s_tvalid,
    input  wire                            o_s_tready,
    input  wire                            o_m_tvalid,
    input  wire                            i_m_tready,
    input  wire [gbn_pkg::M_TDATA_W-1:0]   o_m_tdata,
    input  wire                            o_m_tuser,
    input  wire                            o_m_tlast
);
    import gbn_pkg::*;

    // a stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=>
            o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser) && $stable(o_m_tlast))
        else $error("output word changed while stalled");

    // one step at a time: busy right after a word is taken
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("input taken while a step is in progress");

    // a word with no packet carries zero sequence and payload
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser |-> o_m_tdata[SEQ_W + PAY_W - 1:0] == '0)
        else $error("empty word carries packet fields");

    // a buffered message gives a single word
    a_acc_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[SEQ_W + PAY_W] |-> o_m_tlast)
        else $error("accepted flag on a word that is not the last");

endmodule

bind go_back_n_sender gbn_chk u_gbn_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser),
    .o_m_tlast  (o_m_tlast)
);

`default_nettype wire

>>> tb/tb_go_back_n_sender.sv
// tb_go_back_n_sender: self-checking bench for the go-back-n sender, a directed table then
// random runs under several window and timeout settings, each word checked against a model
// depends on gbn_pkg and go_back_n_sender
`timescale 1ns / 1ps

module tb_go_back_n_sender;

    import gbn_pkg::*;

    localparam int WATCHDOG_LIMIT  = 5000;
    localparam int PRESSURE_CYCLES = 400;
    localparam int CFG_SETTLE      = 12;
    localparam int DRAIN_TAIL      = 40;
    localparam int PHASES          = 6;

    // one input word as the block sees it
    typedef struct packed {
        logic [1:0]       op;
        logic [PAY_W-1:0] payload;
        logic [SEQ_W-1:0] ack_seq;
        logic             ack_corrupt;
        logic             ack_positive;
    } t_word_in;

    // one output word
    typedef struct packed {
        logic             send_valid;
        logic [SEQ_W-1:0] send_seq;
        logic [PAY_W-1:0] send_payload;
        logic             accepted;
        logic             timer_active;
        logic             last;
    } t_word_out;

    typedef enum logic {ROW_ITEM, ROW_CFG} t_row_kind;

    // one line of the directed table
    typedef struct packed {
        t_row_kind             kind;
        t_word_in              item;
        logic                  has_exp;
        t_word_out             exp_word;
        logic [CFG_ADDR_W-1:0] reg_idx;
        logic [CFG_W-1:0]      reg_val;
    } t_stim_row;

    // dut ports
    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    // payload, ack_seq, ack_corrupt, ack_positive, zero pad
    logic [S_TDATA_W-1:0]  i_s_tdata = '0;
    // operation
    logic [S_TUSER_W-1:0]  i_s_tuser = '0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr = '0;
    logic [CFG_W-1:0]      i_cfg_data = '0;
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    // send_seq, send_payload, accepted, timer_active, zero pad
    logic [M_TDATA_W-1:0]  o_m_tdata;
    // send_valid
    logic                  o_m_tuser;
    logic                  o_m_tlast;

    // model of the sender
    logic [WINREG_W-1:0] win_reg = WIN_RST;
    logic [TMO_W-1:0]    tmo_reg = TMO_RST;
    logic [SEQ_W-1:0]    win_base = SEQ_RST;
    logic [SEQ_W-1:0]    next_seq = SEQ_RST;
    logic [PAY_W-1:0]    pkt_store [BUF_DEPTH];
    logic [SEQ_W-1:0]    tick_count = '0;
    logic                timer_run = 1'b0;
    int                  base_slot = 0;
    int                  sent_cnt = 0;

    t_word_out owed_words [$];

    // bookkeeping
    int mismatches = 0;
    int words_in = 0;
    int words_out = 0;
    int regs_written = 0;
    int replayed_pkts = 0;
    int refused_msgs = 0;

    // flow control knobs shared with the receiver
    logic steady_flow = 1'b0;
    logic pressure_pending = 1'b0;
    int   hold_left = 0;

    go_back_n_sender u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic t_word_out pkt_word(input logic v, input logic [SEQ_W-1:0] seq,
                                           input logic [PAY_W-1:0] pay, input logic acc);
        t_word_out r;
        r.send_valid   = v;
        r.send_seq     = seq;
        r.send_payload = pay;
        r.accepted     = acc;
        r.timer_active = 1'b0;
        r.last         = 1'b0;
        return r;
    endfunction

    // one step of the sender: updates the model and queues the words it owes
    function automatic int gbn_step(input t_word_in w);
        t_word_out r [WINDOW_MAX];
        int        cnt;
        int        outst;
        int        win;
        int        d;
        int        m;
        int        lim;
        int        i;
        cnt   = 0;
        outst = int'(SEQ_W'(next_seq - win_base));
        win   = (win_reg < 1) ? 1 : (win_reg > WINDOW_MAX) ? WINDOW_MAX : int'(win_reg);
        case (w.op)
            OP_NEW: begin
                if (outst < CAPACITY) begin
                    pkt_store[(base_slot + outst) % BUF_DEPTH] = w.payload;
                    if (outst < win) begin
                        r[cnt] = pkt_word(1'b1, next_seq, w.payload, 1'b1);
                        if (sent_cnt < outst + 1)
                            sent_cnt = outst + 1;
                        if (outst == 0) begin
                            timer_run  = 1'b1;
                            tick_count = '0;
                        end
                    end else begin
                        // window full, held back until an expiry
                        r[cnt] = pkt_word(1'b0, '0, '0, 1'b1);
                    end
                    next_seq = next_seq + SEQ_W'(1);
                end else begin
                    r[cnt] = pkt_word(1'b0, '0, '0, 1'b0);
                    refused_msgs++;
                end
                cnt++;
            end
            OP_ACK: begin
                if (!w.ack_corrupt && w.ack_positive) begin
                    d = int'(SEQ_W'(w.ack_seq + SEQ_W'(1) - win_base));
                    if (d == 0) begin
                        // duplicate of the last ack only matters once all is acked
                        if (outst == 0)
                            timer_run = 1'b0;
                    end else if (d <= sent_cnt) begin
                        win_base  = win_base + SEQ_W'(d);
                        base_slot = (base_slot + d) % BUF_DEPTH;
                        sent_cnt  = sent_cnt - d;
                        outst     = outst - d;
                        if (outst == 0) begin
                            timer_run = 1'b0;
                        end else begin
                            timer_run  = 1'b1;
                            tick_count = '0;
                        end
                    end
                end
                r[cnt] = pkt_word(1'b0, '0, '0, 1'b0);
                cnt++;
            end
            OP_TICK: begin
                if (timer_run) begin
                    lim = (tmo_reg == 0) ? 1 : int'(tmo_reg);
                    if (tick_count != '1)
                        tick_count = tick_count + SEQ_W'(1);
                    if (int'(tick_count) >= lim) begin
                        // expiry: replay from the base up to the window edge
                        m = (outst < win) ? outst : win;
                        for (i = 0; i < m; i++) begin
                            r[cnt] = pkt_word(1'b1, win_base + SEQ_W'(i),
                                              pkt_store[(base_slot + i) % BUF_DEPTH], 1'b0);
                            cnt++;
                        end
                        replayed_pkts += m;
                        if (sent_cnt < m)
                            sent_cnt = m;
                        if (m == 0) begin
                            timer_run = 1'b0;
                        end else begin
                            timer_run  = 1'b1;
                            tick_count = '0;
                        end
                    end
                end
            end
            default: ;
        endcase
        if (cnt == 0) begin
            r[cnt] = pkt_word(1'b0, '0, '0, 1'b0);
            cnt++;
        end
        for (i = 0; i < cnt; i++) begin
            r[i].timer_active = timer_run;
            r[i].last         = (i == cnt - 1);
            owed_words.push_back(r[i]);
        end
        return cnt;
    endfunction

    // idle length for either side, mostly short
    function automatic int gap_len();
        return ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    endfunction

    // random word, mostly acks near the window so the base keeps moving
    function automatic t_word_in random_word(input int new_pct);
        t_word_in w;
        int       r;
        int       outst;
        r     = $urandom_range(0, 99);
        outst = int'(SEQ_W'(next_seq - win_base));
        w.payload      = {$urandom, $urandom};
        w.ack_seq      = SEQ_W'($urandom);
        w.ack_corrupt  = ($urandom_range(0, 9) == 0);
        w.ack_positive = ($urandom_range(0, 9) != 0);
        if (r < new_pct) begin
            w.op = OP_NEW;
        end else if (r < new_pct + (100 - new_pct) / 2) begin
            w.op = OP_ACK;
            if ($urandom_range(0, 9) < 7)
                w.ack_seq = win_base - SEQ_W'(1) + SEQ_W'($urandom_range(0, outst + 1));
        end else begin
            w.op = OP_TICK;
        end
        return w;
    endfunction

    function automatic t_stim_row item_row(input logic [1:0] op, input logic [PAY_W-1:0] pay,
                                           input logic [SEQ_W-1:0] ack, input logic cor,
                                           input logic pos);
        t_stim_row r;
        r = '0;
        r.kind = ROW_ITEM;
        r.item.op = op;
        r.item.payload = pay;
        r.item.ack_seq = ack;
        r.item.ack_corrupt = cor;
        r.item.ack_positive = pos;
        return r;
    endfunction

    // attach a single typed result to a row
    function automatic t_stim_row checked_row(input t_stim_row r, input logic v,
                                              input logic [SEQ_W-1:0] seq,
                                              input logic [PAY_W-1:0] pay, input logic acc,
                                              input logic tmr);
        t_stim_row c;
        c = r;
        c.has_exp = 1'b1;
        c.exp_word = pkt_word(v, seq, pay, acc);
        c.exp_word.timer_active = tmr;
        c.exp_word.last = 1'b1;
        return c;
    endfunction

    function automatic t_stim_row cfg_row(input logic [CFG_ADDR_W-1:0] idx,
                                          input logic [CFG_W-1:0] val);
        t_stim_row r;
        r = '0;
        r.kind = ROW_CFG;
        r.reg_idx = idx;
        r.reg_val = val;
        return r;
    endfunction

    // offer one word, hold it until taken
    task automatic drive_word(input t_word_in w);
        int gap;
        gap = (!steady_flow && $urandom_range(0, 99) < 35) ? gap_len() : 0;
        if (gap != 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= w.op;
        i_s_tdata  <= S_TDATA_W'({w.ack_positive, w.ack_corrupt, w.ack_seq, w.payload});
        do @(posedge i_clk); while (!o_s_tready);
        words_in++;
    endtask

    // register write once everything owed has come out
    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_W-1:0] val);
        i_s_tvalid <= 1'b0;
        while (owed_words.size() != 0) @(posedge i_clk);
        repeat (CFG_SETTLE) @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == REG_WINDOW)
            win_reg = val[WINREG_W-1:0];
        else
            tmo_reg = val[TMO_W-1:0];
        regs_written++;
    endtask

    function automatic void compare_field(input string name, input logic [PAY_W-1:0] want,
                                          input logic [PAY_W-1:0] seen);
        if (seen !== want) begin
            $error("%s: expected %0h, got %0h", name, want, seen);
            mismatches++;
        end
    endfunction

    // receiver: random stalls plus one long hold-off on request
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            hold_left--;
        end else if (pressure_pending) begin
            hold_left = PRESSURE_CYCLES;
            pressure_pending = 1'b0;
        end else if (!steady_flow && $urandom_range(0, 99) < 25) begin
            hold_left = gap_len();
        end
        i_m_tready <= (hold_left == 0);
    end

    // output check against the oldest owed word
    always @(posedge i_clk) begin
        t_word_out got;
        t_word_out want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.send_valid   = o_m_tuser;
            got.send_seq     = o_m_tdata[15:0];
            got.send_payload = o_m_tdata[79:16];
            got.accepted     = o_m_tdata[80];
            got.timer_active = o_m_tdata[81];
            got.last         = o_m_tlast;
            words_out++;
            if (owed_words.size() == 0) begin
                $error("output word with nothing owed: seq %0h", got.send_seq);
                mismatches++;
            end else begin
                want = owed_words.pop_front();
                compare_field("send_valid", want.send_valid, got.send_valid);
                compare_field("send_seq", want.send_seq, got.send_seq);
                compare_field("send_payload", want.send_payload, got.send_payload);
                compare_field("accepted", want.accepted, got.accepted);
                compare_field("timer_active", want.timer_active, got.timer_active);
                compare_field("last", want.last, got.last);
            end
        end
    end

    // watchdog on cycles with no traffic at all
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) || i_cfg_we)
                quiet = 0;
            else
                quiet++;
        end
        $display("Simulation FAILED");
        $finish;
    end

    // stimulus
    initial begin : stimulus
        t_stim_row rows [$];
        t_word_in  w;
        int        n;
        int        p;
        int        k;
        int        phase_win [PHASES] = '{1, 8, 0, 15, 5, 3};
        int        phase_tmo [PHASES] = '{1, 3, 0, 5, 65535, 2};
        int        phase_len [PHASES] = '{40, 50, 20, 40, 30, 60};
        int        phase_new [PHASES] = '{40, 85, 40, 50, 40, 45};

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: window 4, timeout 1000
        rows.push_back(checked_row(item_row(OP_TICK, '0, '0, 0, 0), 0, 0, 0, 0, 0));
        rows.push_back(checked_row(item_row(OP_ACK, '0, 16'h0000, 0, 1), 0, 0, 0, 0, 0));
        rows.push_back(checked_row(item_row(OP_NEW, '1, '0, 0, 0), 1, 1, '1, 1, 1));
        rows.push_back(checked_row(item_row(OP_NEW, '0, '0, 0, 0), 1, 2, '0, 1, 1));
        // corrupt, negative, beyond last sent, far out
        rows.push_back(checked_row(item_row(OP_ACK, '0, 16'd2, 1, 1), 0, 0, 0, 0, 1));
        rows.push_back(checked_row(item_row(OP_ACK, '0, 16'd2, 0, 0), 0, 0, 0, 0, 1));
        rows.push_back(checked_row(item_row(OP_ACK, '0, 16'd3, 0, 1), 0, 0, 0, 0, 1));
        rows.push_back(checked_row(item_row(OP_ACK, '0, 16'hFFFF, 0, 1), 0, 0, 0, 0, 1));
        // moving the base, then duplicates
        rows.push_back(item_row(OP_ACK, '0, 16'd1, 0, 1));
        rows.push_back(item_row(OP_ACK, '0, 16'd1, 0, 1));
        rows.push_back(item_row(OP_ACK, '0, 16'd2, 0, 1));
        rows.push_back(item_row(OP_ACK, '0, 16'd2, 0, 1));
        // small window and short timeout: window full and expiry
        rows.push_back(cfg_row(REG_WINDOW, 16'd2));
        rows.push_back(cfg_row(REG_TIMEOUT, 16'd2));
        rows.push_back(item_row(OP_NEW, 64'hAAAA_AAAA_AAAA_AAAA, '0, 0, 0));
        rows.push_back(item_row(OP_NEW, 64'h5555_5555_5555_5555, '0, 0, 0));
        rows.push_back(item_row(OP_NEW, 64'h0123_4567_89AB_CDEF, '0, 0, 0));
        rows.push_back(item_row(OP_TICK, '0, '0, 0, 0));
        rows.push_back(item_row(OP_TICK, '0, '0, 0, 0));
        rows.push_back(item_row(OP_ACK, '0, 16'd3, 0, 1));
        rows.push_back(item_row(OP_TICK, '0, '0, 0, 0));
        rows.push_back(item_row(OP_TICK, '0, '0, 0, 0));
        // window of one, timeout of one
        rows.push_back(cfg_row(REG_WINDOW, 16'd1));
        rows.push_back(cfg_row(REG_TIMEOUT, 16'd1));
        rows.push_back(item_row(OP_TICK, '0, '0, 0, 0));
        rows.push_back(item_row(OP_ACK, '0, 16'd5, 0, 1));

        // walk the table
        foreach (rows[k]) begin
            if (rows[k].kind == ROW_CFG) begin
                write_reg(rows[k].reg_idx, rows[k].reg_val);
            end else begin
                drive_word(rows[k].item);
                n = gbn_step(rows[k].item);
                if (rows[k].has_exp) begin
                    repeat (n) void'(owed_words.pop_back());
                    owed_words.push_back(rows[k].exp_word);
                end
            end
        end

        // random phases, each under its own settings
        for (p = 0; p < PHASES; p++) begin
            write_reg(REG_WINDOW, CFG_W'(phase_win[p]));
            write_reg(REG_TIMEOUT, CFG_W'(phase_tmo[p]));
            steady_flow = (p == 3);
            if (p == 1)
                pressure_pending = 1'b1;
            for (k = 0; k < phase_len[p]; k++) begin
                w = random_word(phase_new[p]);
                drive_word(w);
                void'(gbn_step(w));
            end
        end
        steady_flow = 1'b0;

        // drain
        i_s_tvalid <= 1'b0;
        while (owed_words.size() != 0) @(posedge i_clk);
        repeat (DRAIN_TAIL) @(posedge i_clk);

        $display("covered %0d input words and %0d output words over %0d register writes",
                 words_in, words_out, regs_written);
        $display("%0d packets replayed on expiry, %0d new messages refused by a full buffer",
                 replayed_pkts, refused_msgs);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

>>> go_back_n_sender.f
hdl/gbn_pkg.sv
hdl/gbn_ctrl.sv
hdl/gbn_dp.sv
hdl/go_back_n_sender.sv
hdl/gbn_chk.sv
tb/tb_go_back_n_sender.sv
